// ----- sv/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority periodic task scheduler package
// Shared constants, codes and request/response types of the scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int MAX_TASKS = 8;
	localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

	localparam int PRIO_W    = 8;
	localparam int PERIOD_W  = 16;
	localparam int ENTRY_W   = PRIO_W + 2 * PERIOD_W;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [PRIO_W-1:0]   task_priority;
		logic [PERIOD_W-1:0] task_period;
		logic [PERIOD_W-1:0] initial_delay;
	} req_t;

	typedef struct packed {
		logic       dispatched;
		logic [2:0] task_slot;
		logic       status;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0]   prio;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] countdown;
	} entry_t;

endpackage

// ----- sv/priority_periodic_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// Priority periodic task scheduler
// Task table in a RAM, scanned one slot per cycle on every tick request.
// ----------------------------------------------------------------------------
// An add request is answered without a table scan; on a tick request the
// sequencer reads one task slot per cycle from the task RAM, which has one
// read port and one write port. It picks the newest due task of highest
// priority and decrements the other countdowns on the way, then writes the
// reload of the dispatched task. A response that waits for the receiver
// holds the sequencer in its last state. A new request is taken at the
// clock edge after the one that loads the previous response into the
// output register.
module priority_periodic_task_scheduler (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  pps_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output pps_pkg::rsp_t rsp
);

	import pps_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIX,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COUNT_W-1:0]  issue_q;
	logic                rv_s1;
	logic [SLOT_W-1:0]   ridx_s1;
	logic                found_q;
	logic [SLOT_W-1:0]   best_q;
	logic [PRIO_W-1:0]   best_prio_q;
	logic [PERIOD_W-1:0] best_period_q;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                we;
	logic [SLOT_W-1:0]   waddr;
	entry_t              wdata;
	logic                re;
	logic [SLOT_W-1:0]   raddr;
	entry_t              rdata;
	logic                accept;
	logic                full;
	logic                due;
	logic                take;

	pps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_TASKS)
	) u_task_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (count_q >= COUNT_W'(MAX_TASKS));
	assign due       = rv_s1 && (rdata.countdown == '0);
	assign take      = due && (!found_q || (rdata.prio >= best_prio_q));
	assign re        = (state_q == S_SCAN) && (issue_q < count_q);
	assign raddr     = issue_q[SLOT_W-1:0];
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		we    = 1'b0;
		waddr = count_q[SLOT_W-1:0];
		wdata = '{prio: req.task_priority, period: req.task_period,
			countdown: req.initial_delay};
		case (state_q)
			S_IDLE: begin
				we = accept && (req.operation == OP_ADD) && !full;
			end
			S_SCAN: begin
				we    = rv_s1 && (rdata.countdown != '0);
				waddr = ridx_s1;
				wdata = '{prio: rdata.prio, period: rdata.period,
					countdown: rdata.countdown - PERIOD_W'(1)};
			end
			S_FIX: begin
				we    = found_q;
				waddr = best_q;
				wdata = '{prio: best_prio_q, period: best_period_q,
					countdown: (best_period_q == '0) ? '0
						: best_period_q - PERIOD_W'(1)};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			issue_q       <= '0;
			rv_s1         <= 1'b0;
			ridx_s1       <= '0;
			found_q       <= 1'b0;
			best_q        <= '0;
			best_prio_q   <= '0;
			best_period_q <= '0;
			res_q         <= '0;
			rsp_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						issue_q <= '0;
						rv_s1   <= 1'b0;
						found_q <= 1'b0;
						if (req.operation == OP_ADD) begin
							res_q.dispatched <= 1'b0;
							if (full) begin
								res_q.task_slot <= '0;
								res_q.status    <= ST_FULL;
							end else begin
								res_q.task_slot <= 3'(count_q);
								res_q.status    <= ST_OK;
								count_q         <= count_q + COUNT_W'(1);
							end
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rv_s1   <= re;
					ridx_s1 <= raddr;
					if (re) begin
						issue_q <= issue_q + COUNT_W'(1);
					end
					if (take) begin
						found_q       <= 1'b1;
						best_q        <= ridx_s1;
						best_prio_q   <= rdata.prio;
						best_period_q <= rdata.period;
					end
					if (!re && !rv_s1) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					res_q.dispatched <= found_q;
					res_q.task_slot  <= found_q ? 3'(best_q) : 3'd0;
					res_q.status     <= ST_OK;
					state_q          <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_TASKS))
		else $error("task count exceeds table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> !rsp.dispatched)
		else $error("rejected add reports a dispatch");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.operation == OP_ADD) && !full
		|=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("accepted add did not grow the table");

	assert property (@(posedge clk) disable iff (!arst_n)
		we && (state_q != S_IDLE) |-> COUNT_W'(waddr) < count_q)
		else $error("tick writes a slot beyond the table");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.operation == OP_TICK) && (count_q == '0)
		|=> ##2 (state_q == S_DONE) && !res_q.dispatched)
		else $error("tick on empty table dispatched a task");

endmodule

// ----- sv/pps_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority periodic task scheduler testbench
// Drives add and tick requests through the valid/ready request channel and
// checks every response against a cycle-free model of the task table or a
// golden response from the directed table. A short directed table fills the
// task table and walks the corner cases. A long random run of ticks and
// rejected adds follows. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import pps_pkg::*;

	typedef struct {
		req_t item;
		bit   has_golden;
		rsp_t golden;
	} stim_row_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_ready;
	rsp_t  rsp;

	bit    req_has_golden;
	rsp_t  req_golden;
	bit    hold_off_armed;

	logic [PRIO_W-1:0]   shadow_prio      [MAX_TASKS];
	logic [PERIOD_W-1:0] shadow_period    [MAX_TASKS];
	logic [PERIOD_W-1:0] shadow_countdown [MAX_TASKS];
	int unsigned         shadow_fill;

	rsp_t queued_outcomes[$];
	int   mismatch_count;
	int   n_added;
	int   n_rejected;
	int   n_ticks;
	int   n_dispatches;

	priority_periodic_task_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("priority_periodic_task_scheduler test failed");
		$finish;
	end

	function automatic rsp_t schedule_step(req_t r);
		rsp_t              res;
		logic [PRIO_W-1:0] top;
		int                pick;
		res = '0;
		if (r.operation == OP_ADD) begin
			if (shadow_fill >= MAX_TASKS) begin
				res.status = ST_FULL;
			end else begin
				shadow_prio[shadow_fill]      = r.task_priority;
				shadow_period[shadow_fill]    = r.task_period;
				shadow_countdown[shadow_fill] = r.initial_delay;
				res.task_slot = shadow_fill[2:0];
				shadow_fill++;
			end
		end else begin
			top  = '0;
			pick = -1;
			for (int i = 0; i < shadow_fill; i++) begin
				if (shadow_countdown[i] == 0 && shadow_prio[i] > top)
					top = shadow_prio[i];
			end
			for (int i = shadow_fill - 1; i >= 0; i--) begin
				if (shadow_countdown[i] == 0 && shadow_prio[i] == top) begin
					pick = i;
					break;
				end
			end
			if (pick >= 0) begin
				shadow_countdown[pick] = shadow_period[pick];
				res.dispatched = 1'b1;
				res.task_slot  = pick[2:0];
			end
			for (int i = 0; i < shadow_fill; i++) begin
				if (shadow_countdown[i] != 0)
					shadow_countdown[i] = shadow_countdown[i] - PERIOD_W'(1);
			end
		end
		return res;
	endfunction

	function automatic stim_row_t make_row(logic op, logic [PRIO_W-1:0] prio,
			logic [PERIOD_W-1:0] period, logic [PERIOD_W-1:0] delay,
			bit has_golden, rsp_t golden);
		stim_row_t row;
		row.item.operation     = op;
		row.item.task_priority = prio;
		row.item.task_period   = period;
		row.item.initial_delay = delay;
		row.has_golden         = has_golden;
		row.golden             = golden;
		return row;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(25, 60);
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic send_request(stim_row_t row);
		req            <= row.item;
		req_has_golden <= row.has_golden;
		req_golden     <= row.golden;
		req_valid      <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic idle_sender(int cycles);
		if (cycles > 0) begin
			req_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				want = schedule_step(req);
				if (req.operation == OP_ADD) begin
					if (want.status == ST_FULL)
						n_rejected++;
					else
						n_added++;
				end else begin
					n_ticks++;
					if (want.dispatched)
						n_dispatches++;
				end
				queued_outcomes.push_back(req_has_golden ? req_golden : want);
			end
			if (rsp_valid && rsp_ready) begin
				if (queued_outcomes.size() == 0) begin
					report_mismatch($sformatf(
						"response with no request outstanding: dispatched=%0b slot=%0d status=%0b",
						rsp.dispatched, rsp.task_slot, rsp.status));
				end else begin
					want = queued_outcomes.pop_front();
					if (rsp.dispatched !== want.dispatched)
						report_mismatch($sformatf("dispatched got %0b want %0b",
							rsp.dispatched, want.dispatched));
					if (rsp.task_slot !== want.task_slot)
						report_mismatch($sformatf("task_slot got %0d want %0d",
							rsp.task_slot, want.task_slot));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0b want %0b",
							rsp.status, want.status));
				end
			end
		end
	end

	initial begin
		int  roll;
		bit  hold_done;
		rsp_ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			roll = $urandom_range(0, 99);
			if (hold_off_armed && !hold_done) begin
				hold_done = 1'b1;
				rsp_ready <= 1'b0;
				for (int c = 0; c < 400; c++)
					@(posedge clk);
			end else if (roll < 15) begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(40, 120)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b0;
				repeat (1 + pick_gap()) @(posedge clk);
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		stim_row_t dir_rows[$];
		stim_row_t row;
		int        spin;

		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		req_has_golden = 1'b0;
		req_golden     = '0;
		hold_off_armed = 1'b0;
		shadow_fill    = 0;
		mismatch_count = 0;
		n_added        = 0;
		n_rejected     = 0;
		n_ticks        = 0;
		n_dispatches   = 0;

		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b1,
			{1'b0, 3'd0, ST_OK}));
		dir_rows.push_back(make_row(OP_ADD, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1,
			{1'b0, 3'd0, ST_OK}));
		dir_rows.push_back(make_row(OP_ADD, 8'd255, 16'hFFFF, 16'd2, 1'b1,
			{1'b0, 3'd1, ST_OK}));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, '0));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, 8'd7, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, 8'd7, 16'd4, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, 8'd200, 16'd3, 16'd1, 1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, 8'd100, 16'd2, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, PRIO_W'($urandom_range(0, 255)),
			PERIOD_W'($urandom_range(0, 6)), PERIOD_W'($urandom_range(0, 6)),
			1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, PRIO_W'($urandom_range(0, 255)),
			PERIOD_W'($urandom_range(0, 6)), PERIOD_W'($urandom_range(0, 6)),
			1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, 8'd9, 16'd1, 16'd1, 1'b1,
			{1'b0, 3'd0, ST_FULL}));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0, '0));
		dir_rows.push_back(make_row(OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1,
			{1'b0, 3'd0, ST_FULL}));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i]);
			idle_sender(pick_gap());
		end

		for (int k = 0; k < 730; k++) begin
			row.item.operation     = ($urandom_range(0, 99) < 70) ? OP_TICK : OP_ADD;
			row.item.task_priority = PRIO_W'($urandom_range(0, 255));
			row.item.task_period   = PERIOD_W'($urandom_range(0, 65535));
			row.item.initial_delay = PERIOD_W'($urandom_range(0, 65535));
			row.has_golden         = 1'b0;
			row.golden             = '0;
			if (k == 150)
				hold_off_armed = 1'b1;
			send_request(row);
			if (k == 450) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (queued_outcomes.size() != 0)
					@(posedge clk);
			end else if (k < 300 || k >= 400) begin
				idle_sender(pick_gap());
			end
		end
		req_valid <= 1'b0;

		for (spin = 0; spin < 50000 && queued_outcomes.size() != 0; spin++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (queued_outcomes.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived",
				queued_outcomes.size()));

		$display("Run covered %0d ticks (%0d dispatched) and %0d adds (%0d rejected on a full table).",
			n_ticks, n_dispatches, n_added + n_rejected, n_rejected);
		$display("Response checks found %0d mismatches.", mismatch_count);
		if (mismatch_count == 0)
			$display("priority_periodic_task_scheduler test passed");
		else
			$display("priority_periodic_task_scheduler test failed");
		$finish;
	end

endmodule
